>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ttm_pkg.sv
// Shared widths, constants and helpers for the tap tempo block.
package ttm_pkg;
  localparam int DEPTH     = 30;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int TS_W      = 48;
  localparam int GAP_W     = 26;
  localparam int MINI_W    = 5;
  localparam int TEMPO_W   = 18;
  localparam int FOUND_W   = 5;
  localparam int USED_W    = 4;
  localparam int SUM_W     = GAP_W + CNT_W;
  localparam int CONST_W   = 34;
  localparam int NUM_W     = CONST_W + CNT_W;
  localparam int DCNT_W    = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [CONST_W-1:0] US_PER_MIN_Q8 = 34'd15360000000;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX     = '1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INT = 1'b1;

  // x / 3 for x below 64 via reciprocal 171/512
  function automatic logic [CNT_W-1:0] div3(input logic [CNT_W:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd171;
    return CNT_W'(p >> 9);
  endfunction
endpackage

>>> rtl/ttm_div.sv
// Restoring divider, one quotient bit per cycle.
module ttm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ttm_pkg::NUM_W-1:0]   num,
  input  logic [ttm_pkg::SUM_W-1:0]   den,
  output logic                        done,
  output logic [ttm_pkg::NUM_W-1:0]   quot
);
  logic [ttm_pkg::NUM_W-1:0]  n;
  logic [ttm_pkg::SUM_W-1:0]  r;
  logic [ttm_pkg::SUM_W:0]    trial;
  logic [ttm_pkg::DCNT_W-1:0] cnt;
  logic                       busy;

  assign trial = {r, n[ttm_pkg::NUM_W-1]};
  assign quot  = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == ttm_pkg::DCNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= ttm_pkg::DCNT_W'(ttm_pkg::NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ttm_pkg::DCNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n <= num;
      r <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        r <= ttm_pkg::SUM_W'(trial - {1'b0, den});
        n <= {n[ttm_pkg::NUM_W-2:0], 1'b1};
      end else begin
        r <= trial[ttm_pkg::SUM_W-1:0];
        n <= {n[ttm_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

>>> rtl/tap_tempo_trimmed_mean.sv
// Tap tempo estimator: history walk, rank-based trimmed mean, tempo divide.
//  channel  | handshake            | payload
//  tap      | tap_valid/tap_stall  | tap_time_us
//  result   | res_valid/res_stall  | tempo_valid, tempo_bpm_q8, intervals_found, intervals_used
//  config   | cfg_we               | cfg_index, cfg_data
// A tap makes R history reads before the next tap can be accepted (R is N or N+1
// for N intervals found). Forming a tempo adds a ranking pass on the one gap memory
// read port and a divide, one quotient bit a cycle; a zero sum skips the divider. A
// pending result does not block the next tap; a stalled result holds the finish step.
// Reset is synchronous; history contents are unused until written, so there is no
// clearing pass.
module tap_tempo_trimmed_mean (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tap_valid,
  output logic                            tap_stall,
  input  logic [ttm_pkg::TS_W-1:0]        tap_time_us,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic                            tempo_valid,
  output logic [ttm_pkg::TEMPO_W-1:0]     tempo_bpm_q8,
  output logic [ttm_pkg::FOUND_W-1:0]     intervals_found,
  output logic [ttm_pkg::USED_W-1:0]      intervals_used,
  input  logic                            cfg_we,
  input  logic [ttm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttm_pkg::GAP_W-1:0]       cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_WRD = 4'd1, S_WCHK = 4'd2, S_EVAL = 4'd3,
                         S_RKI = 4'd4, S_RKIW = 4'd5, S_RKJ = 4'd6, S_RKJW = 4'd7,
                         S_RKADD = 4'd8, S_DSET = 4'd9, S_DWAIT = 4'd10, S_FIN = 4'd11;

  logic [3:0] state;
  logic [ttm_pkg::GAP_W-1:0]  max_gap;
  logic [ttm_pkg::MINI_W-1:0] min_int;

  logic [ttm_pkg::TS_W-1:0]  hist_mem [ttm_pkg::DEPTH];
  logic [ttm_pkg::GAP_W-1:0] gap_mem  [ttm_pkg::DEPTH];
  logic [ttm_pkg::TS_W-1:0]  hq;
  logic [ttm_pkg::GAP_W-1:0] gq;

  logic [ttm_pkg::ADDR_W-1:0] head, rptr, wptr, gaddr;
  logic [ttm_pkg::CNT_W-1:0]  taps_stored, count, i, j, rank, n1, n2;
  logic [ttm_pkg::TS_W-1:0]   now, cur, d;
  logic [ttm_pkg::GAP_W-1:0]  gi;
  logic [ttm_pkg::SUM_W-1:0]  sum;
  logic                       tv;
  logic                       div_start, div_done;
  logic [ttm_pkg::NUM_W-1:0]  div_num, div_quot;
  logic [ttm_pkg::TEMPO_W-1:0] tempo;
  logic                       fin_go, less;

  assign tap_stall = (state != S_IDLE);
  assign d         = cur - hq;
  assign wptr      = (head == ttm_pkg::ADDR_W'(ttm_pkg::DEPTH - 1)) ? '0 : head + 1'b1;
  assign gaddr     = (state == S_RKI) ? i[ttm_pkg::ADDR_W-1:0] : j[ttm_pkg::ADDR_W-1:0];
  assign fin_go    = (state == S_FIN) && !(res_valid && res_stall);
  assign less      = (gq < gi) || ((gq == gi) && (j < i));
  assign div_start = (state == S_DSET) && (sum != '0);
  assign div_num   = ttm_pkg::NUM_W'(ttm_pkg::US_PER_MIN_Q8) * ttm_pkg::NUM_W'(n2 - n1);

  ttm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (sum),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    hq <= hist_mem[rptr];
    gq <= gap_mem[gaddr];
    if (fin_go) hist_mem[wptr] <= now;
    if ((state == S_WCHK) && (d <= ttm_pkg::TS_W'(max_gap)))
      gap_mem[count[ttm_pkg::ADDR_W-1:0]] <= d[ttm_pkg::GAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap <= ttm_pkg::GAP_W'(6000000);
      min_int <= ttm_pkg::MINI_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttm_pkg::REG_MAX_GAP: max_gap <= cfg_data;
        ttm_pkg::REG_MIN_INT: min_int <= cfg_data[ttm_pkg::MINI_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      taps_stored <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (tap_valid) begin
          now   <= tap_time_us;
          cur   <= tap_time_us;
          i     <= '0;
          count <= '0;
          rptr  <= head;
          state <= (taps_stored == '0) ? S_EVAL : S_WRD;
        end
        S_WRD: state <= S_WCHK;
        S_WCHK: begin
          if (d > ttm_pkg::TS_W'(max_gap)) begin
            state <= S_EVAL;
          end else begin
            count <= count + 1'b1;
            cur   <= hq;
            i     <= i + 1'b1;
            rptr  <= (rptr == '0) ? ttm_pkg::ADDR_W'(ttm_pkg::DEPTH - 1) : rptr - 1'b1;
            state <= (ttm_pkg::CNT_W'(i + 1'b1) == taps_stored) ? S_EVAL : S_WRD;
          end
        end
        S_EVAL: begin
          n1    <= ttm_pkg::div3({1'b0, count});
          n2    <= ttm_pkg::div3({count, 1'b0});
          i     <= '0;
          sum   <= '0;
          tempo <= '0;
          tv    <= 1'b0;
          if ((32'(count) >= 32'(min_int)) &&
              (ttm_pkg::div3({count, 1'b0}) > ttm_pkg::div3({1'b0, count}))) begin
            tv    <= 1'b1;
            state <= S_RKI;
          end else begin
            state <= S_FIN;
          end
        end
        S_RKI: state <= S_RKIW;
        S_RKIW: begin
          gi    <= gq;
          j     <= '0;
          rank  <= '0;
          state <= S_RKJ;
        end
        S_RKJ: state <= S_RKJW;
        S_RKJW: begin
          if (less) rank <= rank + 1'b1;
          j     <= j + 1'b1;
          state <= (ttm_pkg::CNT_W'(j + 1'b1) == count) ? S_RKADD : S_RKJ;
        end
        S_RKADD: begin
          if ((rank >= n1) && (rank < n2)) sum <= sum + ttm_pkg::SUM_W'(gi);
          i     <= i + 1'b1;
          state <= (ttm_pkg::CNT_W'(i + 1'b1) == count) ? S_DSET : S_RKI;
        end
        S_DSET: begin
          if (sum == '0) begin
            tempo <= ttm_pkg::TEMPO_MAX;
            state <= S_FIN;
          end else begin
            state <= S_DWAIT;
          end
        end
        S_DWAIT: if (div_done) begin
          tempo <= (div_quot > ttm_pkg::NUM_W'(ttm_pkg::TEMPO_MAX)) ?
                   ttm_pkg::TEMPO_MAX : div_quot[ttm_pkg::TEMPO_W-1:0];
          state <= S_FIN;
        end
        S_FIN: if (fin_go) begin
          tempo_valid     <= tv;
          tempo_bpm_q8    <= tempo;
          intervals_found <= (32'(count) > 32'd31) ? 5'd31 : ttm_pkg::FOUND_W'(count);
          intervals_used  <= !tv ? '0 :
                             (32'(n2 - n1) > 32'd15) ? 4'd15 : ttm_pkg::USED_W'(n2 - n1);
          head            <= wptr;
          if (32'(taps_stored) < ttm_pkg::DEPTH) taps_stored <= taps_stored + 1'b1;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/ttm_checker.sv
// Port-level checks for the tap tempo block, bound to the top level.
`include "assert_macros.svh"
module ttm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_stall,
  input logic                          tempo_valid,
  input logic [ttm_pkg::TEMPO_W-1:0]   tempo_bpm_q8,
  input logic [ttm_pkg::FOUND_W-1:0]   intervals_found,
  input logic [ttm_pkg::USED_W-1:0]    intervals_used
);
  `ASSERT_ON(a_res_hold, res_valid && res_stall |=> res_valid, "result dropped while stalled")
  `ASSERT_ON(a_no_tempo, res_valid && !tempo_valid |-> (tempo_bpm_q8 == '0) && (intervals_used == '0), "stray tempo")
  `ASSERT_ON(a_used_le, res_valid |-> 32'(intervals_used) <= 32'(intervals_found), "used above found")
  `ASSERT_ALWAYS(a_rst_clr, rst |=> !res_valid, "result after reset")
endmodule

bind tap_tempo_trimmed_mean ttm_checker u_ttm_checker (.*);
